// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions on clock, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/hbf_pkg.sv =====
// ---------------------------------------------------------------------------
// hbf_pkg
// Types, codes and host pattern tables of the hostname block filter.
// ---------------------------------------------------------------------------
package hbf_pkg;

   localparam int COUNT_BITS_DEF   = 32;
   localparam int MAX_NAME_LEN_DEF = 255;
   localparam int RSP_COUNT_W      = 32;

   localparam int WIN_LEN    = 19;
   localparam int WIN_BITS   = WIN_LEN * 8;
   localparam int EXACT_N    = 8;
   localparam int EXACT_MAX  = 33;
   localparam int EXACT_BITS = EXACT_MAX * 8;
   localparam int RULE_N     = 3;
   localparam int KEEP_FIRST = 1;
   localparam int KEEP_LAST  = 4;
   localparam int ORIG_FIRST = 5;
   localparam int SUFFIX_LEN = 14;

   typedef enum logic [1:0] {
      FUNC_CHAR  = 2'd0,
      FUNC_END   = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      NEST_UNKNOWN = 2'd0,
      NEST_OUTER   = 2'd1,
      NEST_INNER   = 2'd2
   } nest_type;

   typedef struct packed {
      func_type   func;
      logic [7:0] name_char;
   } item_type;

   typedef struct packed {
      logic       take;
      logic       flush;
      logic [7:0] name_char;
   } track_ctl_type;

   typedef struct packed {
      logic [EXACT_N-1:0] exact_hit;
      logic               suffix_hit;
      logic               rule_hit;
   } match_type;

   // host text, right aligned: last character in the low byte
   localparam logic [5:0] EXACT_LEN [EXACT_N] = '{
      6'd13, 6'd18, 6'd17, 6'd20, 6'd21, 6'd33, 6'd20, 6'd28
   };

   localparam logic [EXACT_BITS-1:0] EXACT_TEXT [EXACT_N] = '{
      264'h70726f74617269756d2e6c6f6c,
      264'h646973632e70726f74617269756d2e6c6f6c,
      264'h6170692e70726f74617269756d2e6c6f6c,
      264'h706f7274616c2e70726f74617269756d2e6c6f6c,
      264'h6163636f756e742e70726f74617269756d2e6c6f6c,
      264'h73736c2e776168702e7761682e7775702e6170702e6e696e74656e646f2e6e6574,
      264'h676f736861776b2e636170636f6d2e636f2e6a70,
      264'h6d6172732e70726f6a6563742d74726561737572652e626e672e6a70
   };

   localparam logic [4:0] RULE_LEN [RULE_N] = '{5'd13, 5'd14, 5'd19};

   localparam logic [WIN_BITS-1:0] RULE_TEXT [RULE_N] = '{
      152'h64656d6f6e776172652e6e6574,
      152'h6a7573742d64616e63652e636f6d,
      152'h75626973657276696365732e7562692e636f6d
   };

   localparam logic [WIN_BITS-1:0] SUFFIX_TEXT = 152'h2e70726f74617269756d2e6c6f6c;

   // newest byte of the window is the low byte
   function automatic logic ends_with(input logic [WIN_BITS-1:0] win,
                                      input logic [WIN_BITS-1:0] text,
                                      input logic [4:0]          len);
      logic hit;
      hit = 1'b1;
      for (int j = 0; j < WIN_LEN; j++) begin
         if (5'(j) < len && win[j*8 +: 8] != text[j*8 +: 8]) begin
            hit = 1'b0;
         end
      end
      return hit;
   endfunction

endpackage

// ===== sv/hbf_in_stage.sv =====
// ---------------------------------------------------------------------------
// hbf_in_stage
// Input register of the request channel; holds a beat until it is taken.
// ---------------------------------------------------------------------------
module hbf_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_func,
   input  logic [7:0]        req_name_char,
   input  logic              take,
   output logic              item_valid,
   output hbf_pkg::item_type item
);
   import hbf_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;
   logic     load;

   assign req_stall  = valid_ff && !take;
   assign load       = req_valid && !req_stall;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in          = 1'b1;
         item_in.func      = func_type'(req_func);
         item_in.name_char = req_name_char;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// ===== sv/hbf_name_track.sv =====
// ---------------------------------------------------------------------------
// hbf_name_track
// Folds case, shifts the name window, tracks live exact matches, rule hits and the suffix.
// ---------------------------------------------------------------------------
module hbf_name_track #(
   parameter int MAX_NAME_LEN = hbf_pkg::MAX_NAME_LEN_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hbf_pkg::track_ctl_type ctl,
   output hbf_pkg::match_type     match
);
   import hbf_pkg::*;

   localparam int POS_BITS = $clog2(MAX_NAME_LEN + 1);

   logic [WIN_BITS-1:0] window_ff;
   logic [WIN_BITS-1:0] window_in;
   logic [POS_BITS-1:0] pos_ff;
   logic [POS_BITS-1:0] pos_in;
   logic [EXACT_N-1:0]  alive_ff;
   logic [EXACT_N-1:0]  alive_in;
   logic [RULE_N-1:0]   rule_ff;
   logic [RULE_N-1:0]   rule_in;
   logic [7:0]          folded;
   logic [WIN_BITS-1:0] window_shift;

   assign folded       = (ctl.name_char inside {[8'h41:8'h5a]}) ?
                         ctl.name_char + 8'h20 : ctl.name_char;
   assign window_shift = {window_ff[WIN_BITS-9:0], folded};

   always_comb begin
      logic [5:0] idx;
      logic       live;
      window_in = window_ff;
      pos_in    = pos_ff;
      alive_in  = alive_ff;
      rule_in   = rule_ff;
      idx       = '0;
      live      = 1'b0;
      if (ctl.flush) begin
         window_in = '0;
         pos_in    = '0;
         alive_in  = '1;
         rule_in   = '0;
      end else if (ctl.take) begin
         window_in = window_shift;
         for (int k = 0; k < EXACT_N; k++) begin
            idx  = EXACT_LEN[k] - 6'd1 - pos_ff[5:0];
            live = (pos_ff < POS_BITS'(EXACT_LEN[k])) &&
                   (EXACT_TEXT[k][idx*8 +: 8] == folded);
            alive_in[k] = alive_ff[k] && live;
         end
         for (int k = 0; k < RULE_N; k++) begin
            if (ends_with(window_shift, RULE_TEXT[k], RULE_LEN[k])) begin
               rule_in[k] = 1'b1;
            end
         end
         if (pos_ff != POS_BITS'(MAX_NAME_LEN)) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < EXACT_N; k++) begin
         match.exact_hit[k] = alive_ff[k] && (pos_ff == POS_BITS'(EXACT_LEN[k]));
      end
      match.suffix_hit = (pos_ff >= POS_BITS'(SUFFIX_LEN)) &&
                         ends_with(window_ff, SUFFIX_TEXT, 5'(SUFFIX_LEN));
      match.rule_hit   = |rule_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         pos_ff    <= '0;
         alive_ff  <= '1;
         rule_ff   <= '0;
      end else begin
         window_ff <= window_in;
         pos_ff    <= pos_in;
         alive_ff  <= alive_in;
         rule_ff   <= rule_in;
      end
   end

endmodule

// ===== sv/hostname_block_filter.sv =====
// ---------------------------------------------------------------------------
// hostname_block_filter
// Hostname refusal filter: byte-serial name match with lookup counters.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one beat per hostname byte (func char), an end-of-name beat
//            (func end) or a counter clear (func clear). Code 3 is dropped.
//   rsp_*  : one beat per end-of-name beat with the refusal flag, nesting
//            and both counters after that name.
//   csr_*  : write of refusal_mode, ready at all times; write only when idle.
// Throughput: one request beat per cycle while req_stall is low. Each beat is
//   held in the input register and applied from it; the result register is
//   loaded when an end beat is applied, so a response passes both registers.
// Stall: while rsp_stall holds a result, byte and clear beats keep flowing;
//   an end beat waits in the input register, which then stalls req.
// Reset: empty pipeline, cleared name state, counters zero, nesting
//   unknown, refusals off.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hostname_block_filter #(
   parameter int COUNT_BITS   = hbf_pkg::COUNT_BITS_DEF,
   parameter int MAX_NAME_LEN = hbf_pkg::MAX_NAME_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_name_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_refuse_lookup,
   output logic [1:0]  rsp_nesting_seen,
   output logic [31:0] rsp_lookups_total,
   output logic [31:0] rsp_lookups_refused,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_refusal_mode
);
   import hbf_pkg::*;

   logic                  item_valid;
   item_type              item;
   logic                  fire;
   logic                  out_free;
   track_ctl_type         ctl;
   match_type             match;

   logic                  mode_ff;
   logic [COUNT_BITS-1:0] seen_ff;
   logic [COUNT_BITS-1:0] seen_in;
   logic [COUNT_BITS-1:0] refused_ff;
   logic [COUNT_BITS-1:0] refused_in;
   nest_type              nest_ff;
   nest_type              nest_in;
   logic                  refuse;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  refuse_ff;
   logic [RSP_COUNT_W-1:0] total_view;
   logic [RSP_COUNT_W-1:0] refused_view;
   logic [RSP_COUNT_W-1:0] total_ff;
   logic [RSP_COUNT_W-1:0] refused_out_ff;

   hbf_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_name_char (req_name_char),
      .take          (fire),
      .item_valid    (item_valid),
      .item          (item)
   );

   hbf_name_track #(
      .MAX_NAME_LEN (MAX_NAME_LEN)
   ) u_name_track (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .match (match)
   );

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = item_valid && (item.func != FUNC_END || out_free);

   assign ctl.take      = fire && item.func == FUNC_CHAR;
   assign ctl.flush     = fire && item.func == FUNC_END;
   assign ctl.name_char = item.name_char;

   always_comb begin
      logic prot;
      logic keep;
      logic orig;
      prot    = match.exact_hit[0] || match.suffix_hit;
      keep    = |match.exact_hit[KEEP_LAST:KEEP_FIRST];
      orig    = |match.exact_hit[EXACT_N-1:ORIG_FIRST] || match.rule_hit;
      refuse  = 1'b0;
      nest_in = nest_ff;
      if (mode_ff) begin
         if (prot) begin
            if (!keep) begin
               refuse  = 1'b1;
               nest_in = NEST_INNER;
            end
         end else if (orig) begin
            refuse  = 1'b1;
            nest_in = NEST_OUTER;
         end
      end
   end

   always_comb begin
      seen_in      = seen_ff;
      refused_in   = refused_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fire) begin
         case (item.func)
            FUNC_END: begin
               seen_in      = seen_ff + 1'b1;
               refused_in   = refused_ff + COUNT_BITS'(refuse);
               rsp_valid_in = 1'b1;
            end
            FUNC_CLEAR: begin
               seen_in    = '0;
               refused_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   if (COUNT_BITS >= RSP_COUNT_W) begin : g_wide
      assign total_view   = seen_in[RSP_COUNT_W-1:0];
      assign refused_view = refused_in[RSP_COUNT_W-1:0];
   end else begin : g_narrow
      assign total_view   = {{(RSP_COUNT_W-COUNT_BITS){1'b0}}, seen_in};
      assign refused_view = {{(RSP_COUNT_W-COUNT_BITS){1'b0}}, refused_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         seen_ff      <= '0;
         refused_ff   <= '0;
         nest_ff      <= NEST_UNKNOWN;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_refusal_mode;
         end
         seen_ff      <= seen_in;
         refused_ff   <= refused_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ctl.flush) begin
            nest_ff <= nest_in;
         end
      end
      if (ctl.flush) begin
         refuse_ff      <= refuse;
         total_ff       <= total_view;
         refused_out_ff <= refused_view;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_refuse_lookup   = refuse_ff;
   assign rsp_nesting_seen    = nest_ff;
   assign rsp_lookups_total   = total_ff;
   assign rsp_lookups_refused = refused_out_ff;

   `ASSERT_NEXT(a_end_gives_rsp, ctl.flush, rsp_valid, "end beat gave no response")
   `ASSERT_SAME(a_refuse_sets_nest, rsp_valid && rsp_refuse_lookup,
                rsp_nesting_seen != NEST_UNKNOWN, "refusal without nesting")
   `ASSERT_SAME(a_end_waits, item_valid && item.func == FUNC_END && rsp_valid && rsp_stall,
                req_stall && !fire, "end beat taken while response held")
   `ASSERT_NEXT(a_clear_zeroes, fire && item.func == FUNC_CLEAR,
                seen_ff == '0 && refused_ff == '0, "clear beat left counters")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Hostname block filter: a directed table of names, then random names with
// mixed case, near misses, raw bytes and overlong names, under random gaps
// and stalls on both channels. Every end-of-name result is checked field by
// field against a table verdict or an in-bench predictor (names, suffixes, rules).
// ---------------------------------------------------------------------------
module testbench;

   import hbf_pkg::*;

   localparam int          PIPE_LAT     = 2;
   localparam int          CYCLE_LIMIT  = 1000000;
   localparam int          RANDOM_BEATS = 500;
   localparam int          PHASE_BEATS  = 250;
   localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
   localparam logic [7:0]  FILL_BYTE    = 8'h71;

   localparam int HOST_DOMAIN = 0;
   localparam int HOST_KEEP_A = KEEP_FIRST;
   localparam int HOST_KEEP_D = KEEP_LAST;
   localparam int HOST_ORIG_A = ORIG_FIRST;
   localparam int HOST_ORIG_B = ORIG_FIRST + 1;
   localparam int HOST_ORIG_C = ORIG_FIRST + 2;
   localparam int HOST_RULE_A = EXACT_N;
   localparam int HOST_RULE_B = EXACT_N + 1;
   localparam int HOST_RULE_C = EXACT_N + 2;
   localparam int HOST_SUFFIX = EXACT_N + RULE_N;
   localparam int HOST_NONE   = HOST_SUFFIX + 1;
   localparam int HOST_COUNT  = HOST_NONE + 1;

   localparam int CASE_KEEP  = 0;
   localparam int CASE_MIX   = 1;
   localparam int CASE_SHOUT = 2;

   typedef struct packed {
      logic        refuse;
      nest_type    nest;
      logic [31:0] total;
      logic [31:0] refused;
   } verdict_type;

   typedef enum int {
      ROW_NAME, ROW_SPLIT, ROW_CLEAR, ROW_UNUSED, ROW_MODE_ON, ROW_MODE_OFF
   } row_kind_type;

   typedef struct {
      row_kind_type kind;
      int           host;
      int           filler;
      logic [63:0]  head;
      int           head_len;
      logic [63:0]  tail;
      int           tail_len;
      int           case_mode;
      logic         typed;
      verdict_type  want;
   } plan_row_type;

   localparam verdict_type NO_VERDICT = '{1'b0, NEST_UNKNOWN, 32'd0, 32'd0};

   plan_row_type plan [24] = '{
      '{ROW_NAME, HOST_NONE, 0, 64'h0, 0, 64'h0, 0, CASE_KEEP, 1'b1,
        '{1'b0, NEST_UNKNOWN, 32'd1, 32'd0}},
      '{ROW_NAME, HOST_DOMAIN, 0, 64'h0, 0, 64'h0, 0, CASE_KEEP, 1'b1,
        '{1'b0, NEST_UNKNOWN, 32'd2, 32'd0}},
      '{ROW_UNUSED, HOST_NONE, 0, 64'h0, 0, 64'h0, 0, CASE_KEEP, 1'b0, NO_VERDICT},
      '{ROW_MODE_ON, HOST_NONE, 0, 64'h0, 0, 64'h0, 0, CASE_KEEP, 1'b0, NO_VERDICT},
      '{ROW_NAME, HOST_DOMAIN, 0, 64'h0, 0, 64'h0, 0, CASE_SHOUT, 1'b1,
        '{1'b1, NEST_INNER, 32'd3, 32'd1}},
      '{ROW_NAME, HOST_KEEP_A, 0, 64'h0, 0, 64'h0, 0, CASE_KEEP, 1'b0, NO_VERDICT},
      '{ROW_NAME, HOST_KEEP_D, 0, 64'h0, 0, 64'h0, 0, CASE_MIX, 1'b0, NO_VERDICT},
      '{ROW_NAME, HOST_SUFFIX, 0, 64'h78, 1, 64'h0, 0, CASE_KEEP, 1'b0, NO_VERDICT},
      '{ROW_NAME, HOST_KEEP_A, 0, 64'h7a, 1, 64'h0, 0, CASE_KEEP, 1'b0, NO_VERDICT},
      '{ROW_NAME, HOST_DOMAIN, 0, 64'h61, 1, 64'h0, 0, CASE_KEEP, 1'b0, NO_VERDICT},
      '{ROW_NAME, HOST_ORIG_A, 0, 64'h0, 0, 64'h0, 0, CASE_SHOUT, 1'b0, NO_VERDICT},
      '{ROW_NAME, HOST_ORIG_C, 0, 64'h0, 0, 64'h0, 0, CASE_KEEP, 1'b0, NO_VERDICT},
      '{ROW_NAME, HOST_ORIG_B, 0, 64'h0, 0, 64'h2e, 1, CASE_KEEP, 1'b0, NO_VERDICT},
      '{ROW_NAME, HOST_RULE_A, 0, 64'h00ff405b415a607b, 8, 64'hff, 1, CASE_KEEP, 1'b0,
        NO_VERDICT},
      '{ROW_NAME, HOST_RULE_B, 0, 64'h0, 0, 64'h00, 1, CASE_KEEP, 1'b0, NO_VERDICT},
      '{ROW_NAME, HOST_RULE_C, 0, 64'h0, 0, 64'h0, 0, CASE_MIX, 1'b0, NO_VERDICT},
      '{ROW_SPLIT, HOST_DOMAIN, 0, 64'h0, 0, 64'h0, 0, CASE_KEEP, 1'b0, NO_VERDICT},
      '{ROW_NAME, HOST_SUFFIX, 270, 64'h0, 0, 64'h0, 0, CASE_KEEP, 1'b0, NO_VERDICT},
      '{ROW_NAME, HOST_DOMAIN, 20, 64'h0, 0, 64'h0, 0, CASE_KEEP, 1'b0, NO_VERDICT},
      '{ROW_NAME, HOST_RULE_A, 20, 64'h00, 1, 64'h0, 0, CASE_KEEP, 1'b0, NO_VERDICT},
      '{ROW_CLEAR, HOST_NONE, 0, 64'h0, 0, 64'h0, 0, CASE_KEEP, 1'b0, NO_VERDICT},
      '{ROW_NAME, HOST_NONE, 0, 64'h0, 0, 64'h0, 0, CASE_KEEP, 1'b0, NO_VERDICT},
      '{ROW_MODE_OFF, HOST_NONE, 0, 64'h0, 0, 64'h0, 0, CASE_KEEP, 1'b0, NO_VERDICT},
      '{ROW_NAME, HOST_SUFFIX, 0, 64'h78, 1, 64'h0, 0, CASE_KEEP, 1'b0, NO_VERDICT}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_CHAR;
   logic [7:0]  req_name_char = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_refuse_lookup;
   logic [1:0]  rsp_nesting_seen;
   logic [31:0] rsp_lookups_total;
   logic [31:0] rsp_lookups_refused;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_refusal_mode = 1'b0;

   logic [7:0]  host_text [HOST_COUNT][$];
   logic [7:0]  draft [$];
   logic [7:0]  name_so_far [$];
   verdict_type verdict_q [$];

   logic        refusal_on = 1'b0;
   nest_type    nest_now = NEST_UNKNOWN;
   logic [31:0] seen_n = 32'd0;
   logic [31:0] refused_n = 32'd0;
   logic        typed_pending = 1'b0;
   verdict_type typed_verdict;

   int          error_count = 0;
   int          cycle_count = 0;
   int          beat_count = 0;
   int          calm_send = 0;
   int          hold_cycles = 0;
   int          calm_cycles = 0;
   bit          hold_request = 1'b0;

   hostname_block_filter u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_name_char       (req_name_char),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_refuse_lookup   (rsp_refuse_lookup),
      .rsp_nesting_seen    (rsp_nesting_seen),
      .rsp_lookups_total   (rsp_lookups_total),
      .rsp_lookups_refused (rsp_lookups_refused),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_refusal_mode    (csr_refusal_mode)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** hostname_block_filter: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------- predictor
   function automatic logic [7:0] fold(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
   endfunction

   function automatic bit matches_at(input int id, input int start);
      for (int i = 0; i < host_text[id].size(); i++) begin
         if (name_so_far[start + i] != host_text[id][i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit name_is(input int id);
      return name_so_far.size() == host_text[id].size() && matches_at(id, 0);
   endfunction

   function automatic bit name_ends(input int id);
      return name_so_far.size() >= host_text[id].size() &&
             matches_at(id, name_so_far.size() - host_text[id].size());
   endfunction

   function automatic bit name_has(input int id);
      for (int s = 0; s + host_text[id].size() <= name_so_far.size(); s++) begin
         if (matches_at(id, s)) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void judge_beat(input logic [1:0] f, input logic [7:0] c);
      verdict_type v;
      bit          kept;
      bit          outer_hit;
      v = NO_VERDICT;
      kept = 1'b0;
      outer_hit = 1'b0;
      case (f)
         FUNC_CHAR: name_so_far.push_back(fold(c));
         FUNC_CLEAR: begin
            seen_n = 32'd0;
            refused_n = 32'd0;
         end
         FUNC_END: begin
            seen_n = seen_n + 32'd1;
            if (refusal_on) begin
               if (name_is(HOST_DOMAIN) || name_ends(HOST_SUFFIX)) begin
                  for (int k = KEEP_FIRST; k <= KEEP_LAST; k++) kept |= name_is(k);
                  if (!kept) begin
                     v.refuse = 1'b1;
                     nest_now = NEST_INNER;
                  end
               end else begin
                  for (int k = ORIG_FIRST; k < EXACT_N; k++) outer_hit |= name_is(k);
                  for (int k = HOST_RULE_A; k <= HOST_RULE_C; k++) outer_hit |= name_has(k);
                  if (outer_hit) begin
                     v.refuse = 1'b1;
                     nest_now = NEST_OUTER;
                  end
               end
            end
            if (v.refuse) refused_n = refused_n + 32'd1;
            v.nest = nest_now;
            v.total = seen_n;
            v.refused = refused_n;
            if (typed_pending) begin
               verdict_q.push_back(typed_verdict);
               typed_pending = 1'b0;
            end else begin
               verdict_q.push_back(v);
            end
            name_so_far.delete();
         end
         default: ;
      endcase
   endfunction

   // --------------------------------------------------------------- checker
   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= 10)
            $display("mismatch on %s: expected %0h, got %0h", field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("result beat with nothing expected");
         end else begin
            want = verdict_q.pop_front();
            check_field("refuse_lookup", 32'(want.refuse), 32'(rsp_refuse_lookup));
            check_field("nesting_seen", 32'(want.nest), 32'(rsp_nesting_seen));
            check_field("lookups_total", want.total, rsp_lookups_total);
            check_field("lookups_refused", want.refused, rsp_lookups_refused);
         end
      end
   end

   // ------------------------------------------------------------ responder
   initial begin
      int r;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_cycles = 400;
            rsp_stall <= 1'b1;
         end else if (calm_cycles > 0) begin
            rsp_stall <= 1'b0;
            calm_cycles--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
               hold_cycles = $urandom_range(15, 60);
               rsp_stall <= 1'b1;
            end else if (r < 6) begin
               calm_cycles = $urandom_range(30, 150);
               rsp_stall <= 1'b0;
            end else begin
               rsp_stall <= (r < 30);
            end
         end
      end
   end

   // --------------------------------------------------------------- sender
   function automatic int pick_gap();
      int r;
      if (calm_send > 0) begin
         calm_send--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_send = $urandom_range(20, 100);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // enter and leave on a falling edge
   task automatic send_beat(input logic [1:0] f, input logic [7:0] c);
      repeat (pick_gap()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_name_char <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (f != FUNC_UNUSED) beat_count++;
      judge_beat(f, c);
      @(negedge clock);
   endtask

   task automatic send_noise();
      int r;
      r = $urandom_range(0, 99);
      if (r < 2) send_beat(FUNC_CLEAR, 8'($urandom));
      else if (r < 4) send_beat(FUNC_UNUSED, 8'($urandom));
   endtask

   task automatic send_name(input int cut, input bit noisy);
      for (int i = 0; i < draft.size(); i++) begin
         if (i == cut) send_beat(FUNC_CLEAR, 8'($urandom));
         if (noisy) send_noise();
         send_beat(FUNC_CHAR, draft[i]);
      end
      send_beat(FUNC_END, 8'($urandom));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 2) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_mode(input logic v);
      csr_valid <= 1'b1;
      csr_refusal_mode <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      refusal_on = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------ name drafts
   function automatic void add_bytes(input logic [63:0] text, input int len);
      for (int i = 0; i < len; i++) draft.push_back(text[(len - 1 - i) * 8 +: 8]);
   endfunction

   function automatic void add_host(input int id, input int case_mode);
      logic [7:0] c;
      for (int i = 0; i < host_text[id].size(); i++) begin
         c = host_text[id][i];
         if (c >= 8'h61 && c <= 8'h7a &&
             (case_mode == CASE_SHOUT || (case_mode == CASE_MIX && $urandom_range(0, 1))))
            c = c - 8'h20;
         draft.push_back(c);
      end
   endfunction

   function automatic void add_junk(input int n);
      int r;
      repeat (n) begin
         r = $urandom_range(0, 39);
         if (r < 26) draft.push_back(8'h61 + 8'(r));
         else if (r < 36) draft.push_back(8'h30 + 8'(r - 26));
         else if (r < 38) draft.push_back(8'h2e);
         else draft.push_back(8'h2d);
      end
   endfunction

   function automatic void draft_random_name();
      int r;
      int k;
      draft.delete();
      r = $urandom_range(0, 99);
      if (r < 30) begin
         add_host($urandom_range(0, EXACT_N - 1), CASE_MIX);
      end else if (r < 50) begin
         add_junk($urandom_range(0, 6));
         add_host(HOST_SUFFIX, CASE_MIX);
         if ($urandom_range(0, 3) == 0) add_junk($urandom_range(1, 3));
      end else if (r < 68) begin
         add_junk($urandom_range(0, 8));
         add_host($urandom_range(HOST_RULE_A, HOST_RULE_C), CASE_MIX);
         add_junk($urandom_range(0, 8));
      end else if (r < 80) begin
         add_host($urandom_range(0, EXACT_N - 1), CASE_MIX);
         k = $urandom_range(0, draft.size() - 1);
         case ($urandom_range(0, 2))
            0: void'(draft.pop_back());
            1: draft[k] = draft[k] ^ 8'h01;
            default: draft.push_front(8'($urandom_range(0, 255)));
         endcase
      end else if (r < 98) begin
         repeat ($urandom_range(0, 20)) draft.push_back(8'($urandom_range(0, 255)));
      end else begin
         add_junk($urandom_range(256, 290));
         add_host($urandom_range(HOST_RULE_A, HOST_SUFFIX), CASE_MIX);
      end
   endfunction

   // ------------------------------------------------------------- stimulus
   initial begin
      int  rand_start;
      int  next_switch;
      int  phase;
      bit  pressure_done;

      for (int k = 0; k < EXACT_N; k++)
         for (int i = 0; i < int'(EXACT_LEN[k]); i++)
            host_text[k].push_back(EXACT_TEXT[k][(int'(EXACT_LEN[k]) - 1 - i) * 8 +: 8]);
      for (int k = 0; k < RULE_N; k++)
         for (int i = 0; i < int'(RULE_LEN[k]); i++)
            host_text[HOST_RULE_A + k].push_back(
               RULE_TEXT[k][(int'(RULE_LEN[k]) - 1 - i) * 8 +: 8]);
      for (int i = 0; i < SUFFIX_LEN; i++)
         host_text[HOST_SUFFIX].push_back(SUFFIX_TEXT[(SUFFIX_LEN - 1 - i) * 8 +: 8]);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         case (plan[i].kind)
            ROW_MODE_ON, ROW_MODE_OFF: begin
               settle();
               write_mode(plan[i].kind == ROW_MODE_ON);
            end
            ROW_CLEAR: send_beat(FUNC_CLEAR, 8'hff);
            ROW_UNUSED: send_beat(FUNC_UNUSED, 8'h41);
            default: begin
               draft.delete();
               repeat (plan[i].filler) draft.push_back(FILL_BYTE);
               add_bytes(plan[i].head, plan[i].head_len);
               if (plan[i].host != HOST_NONE) add_host(plan[i].host, plan[i].case_mode);
               add_bytes(plan[i].tail, plan[i].tail_len);
               typed_pending = plan[i].typed;
               typed_verdict = plan[i].want;
               send_name(plan[i].kind == ROW_SPLIT ? draft.size() / 2 : -1, 1'b0);
            end
         endcase
      end

      phase = 0;
      pressure_done = 1'b0;
      settle();
      write_mode(1'b1);
      rand_start = beat_count;
      next_switch = beat_count + PHASE_BEATS;
      while (beat_count - rand_start < RANDOM_BEATS) begin
         if (beat_count >= next_switch) begin
            phase++;
            settle();
            write_mode(phase % 3 != 1);
            next_switch = beat_count + PHASE_BEATS;
         end
         if (!pressure_done && beat_count - rand_start >= 300) begin
            hold_request = 1'b1;
            pressure_done = 1'b1;
         end
         draft_random_name();
         send_name(-1, 1'b1);
      end

      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
      if (error_count == 0) begin
         $display("** hostname_block_filter: PASSED **");
      end else begin
         $display("** hostname_block_filter: FAILED **");
      end
      $finish;
   end

endmodule
